/* rtl/cma_pkg.sv */
// Shared types, constants and calendar helper functions for the calendar month adder.
// Depends on nothing; every module of the block imports it.
package cma_pkg;

    localparam int unsigned IN_BYTES  = 5;
    localparam int unsigned OUT_BYTES = 3;

    localparam logic [3:0]  MONTH_JAN  = 4'd0;
    localparam logic [3:0]  MONTH_FEB  = 4'd1;
    localparam logic [3:0]  MONTH_LAST = 4'd11;
    localparam logic [4:0]  DAY_FIRST  = 5'd1;
    localparam logic [4:0]  DAY_MAX    = 5'd31;
    localparam logic [13:0] YEAR_MIN   = 14'd0;
    localparam logic [13:0] YEAR_MAX   = 14'd9999;

    // Raw input item as unpacked from the stream word
    typedef struct packed {
        logic [13:0]        year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic signed [11:0] offset;
    } cma_in_t;

    // After month-count build: absolute month index and start-day class
    typedef struct packed {
        logic signed [18:0] total;
        logic [4:0]         day;
        logic               last;
    } cma_total_t;

    // After split of the month index into year and month
    typedef struct packed {
        logic        neg;
        logic [14:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        last;
    } cma_split_t;

    // Final result item
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        oor;
    } cma_res_t;

    // Gregorian leap test; y/100 is taken as (y>>2)/25 through a reciprocal multiply
    function automatic logic is_leap(input logic [13:0] y);
        logic [23:0] prod;
        logic [7:0]  q100;
        logic [13:0] r100;
        prod = {12'd0, y[13:2]} * 24'd2622;
        q100 = prod[23:16];
        r100 = y - 14'({6'd0, q100} * 14'd100);
        return (y[1:0] == 2'b00) && ((r100 != 14'd0) || (q100[1:0] == 2'b00));
    endfunction

    // Month length table with February leap adjustment
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            MONTH_FEB:               d = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
            default:                 d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

/* rtl/cma_month_total.sv */
// Stage one: clamps the start date, classifies the start day and builds the
// absolute month index year*12 + month + offset. Depends on cma_pkg.
module cma_month_total (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  cma_pkg::cma_in_t    in_item,
    output logic                out_valid,
    output cma_pkg::cma_total_t out_item
);
    import cma_pkg::*;

    logic               valid_reg;
    cma_total_t         item_reg;
    cma_total_t         item_next;
    logic [3:0]         sm;
    logic [4:0]         sd;
    logic [4:0]         len_s;
    logic [17:0]        base;
    logic signed [18:0] off_ext;

    // Clamp fields, look up start month length, form month index
    always_comb begin
        sm      = (in_item.month > MONTH_LAST) ? MONTH_LAST : in_item.month;
        sd      = (in_item.day == 5'd0) ? DAY_FIRST : in_item.day;
        len_s   = month_days(sm, is_leap(in_item.year));
        base    = {1'b0, in_item.year, 3'b000} + {2'b00, in_item.year, 2'b00}
                + {14'd0, sm};
        off_ext = {{7{in_item.offset[11]}}, in_item.offset};
        item_next.total = $signed({1'b0, base}) + off_ext;
        item_next.day   = sd;
        item_next.last  = (sd >= len_s);
    end

    // Advance the stage when the pipe moves
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* rtl/cma_year_split.sv */
// Stage two: splits the month index into year and month by a divide-by-12
// through a reciprocal multiply. Depends on cma_pkg.
module cma_year_split (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  cma_pkg::cma_total_t in_item,
    output logic                out_valid,
    output cma_pkg::cma_split_t out_item
);
    import cma_pkg::*;

    logic        valid_reg;
    cma_split_t  item_reg;
    cma_split_t  item_next;
    logic [17:0] x;
    logic [32:0] prod;
    logic [14:0] ry;
    logic [17:0] rem;

    // x/12 = (x>>2)/3, exact for 16-bit (x>>2) with factor ceil(2^17/3)
    always_comb begin
        x    = in_item.total[17:0];
        prod = {17'd0, x[17:2]} * 33'd43691;
        ry   = prod[31:17];
        rem  = x - ({ry, 3'b000} + {1'b0, ry, 2'b00});
        item_next.neg   = in_item.total[18];
        item_next.year  = ry;
        item_next.month = rem[3:0];
        item_next.day   = in_item.day;
        item_next.last  = in_item.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* rtl/cma_day_fix.sv */
// Stage three: saturates out-of-range years, applies the last-day rule and
// clamps the day to the target month. Depends on cma_pkg.
module cma_day_fix (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  cma_pkg::cma_split_t in_item,
    output logic                out_valid,
    output cma_pkg::cma_res_t   out_item
);
    import cma_pkg::*;

    logic       valid_reg;
    cma_res_t   item_reg;
    cma_res_t   item_next;
    logic [4:0] len_t;

    // Pick saturated date or clamped day of target month
    always_comb begin
        len_t = month_days(in_item.month, is_leap(in_item.year[13:0]));
        if (in_item.neg) begin
            item_next.year  = YEAR_MIN;
            item_next.month = MONTH_JAN;
            item_next.day   = DAY_FIRST;
            item_next.oor   = 1'b1;
        end else if (in_item.year > {1'b0, YEAR_MAX}) begin
            item_next.year  = YEAR_MAX;
            item_next.month = MONTH_LAST;
            item_next.day   = DAY_MAX;
            item_next.oor   = 1'b1;
        end else begin
            item_next.year  = in_item.year[13:0];
            item_next.month = in_item.month;
            item_next.day   = (in_item.last || (in_item.day > len_t)) ? len_t : in_item.day;
            item_next.oor   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* rtl/cma_out_skid.sv */
// Output register with a skid entry; gives the pipe a registered ready.
// Depends on cma_pkg for the result type.
module cma_out_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  cma_pkg::cma_res_t in_item,
    output logic              in_ready,
    output logic              out_valid,
    output cma_pkg::cma_res_t out_item,
    input  logic              out_ready
);
    import cma_pkg::*;

    logic     out_valid_reg;
    logic     out_valid_next;
    cma_res_t out_item_reg;
    cma_res_t out_item_next;
    logic     sk_valid_reg;
    logic     sk_valid_next;
    cma_res_t sk_item_reg;
    cma_res_t sk_item_next;
    logic     incoming;

    assign in_ready = !sk_valid_reg;
    assign incoming = in_valid && !sk_valid_reg;

    // Refill the output register, or park the incoming transfer while stalled
    always_comb begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        sk_valid_next  = sk_valid_reg;
        sk_item_next   = sk_item_reg;
        if (out_ready || !out_valid_reg) begin
            out_valid_next = sk_valid_reg || incoming;
            out_item_next  = sk_valid_reg ? sk_item_reg : in_item;
            sk_valid_next  = 1'b0;
        end else if (incoming) begin
            sk_valid_next = 1'b1;
            sk_item_next  = in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            sk_valid_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            sk_valid_reg  <= sk_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_item_reg <= out_item_next;
        sk_item_reg  <= sk_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* rtl/calendar_month_adder_unit.sv */
// Calendar month adder: one date plus a signed month offset per transfer.
// Registered path: input, month total, year split, day fix and output registers.
// Throughput: one transfer per cycle; the stall-all pipe is paced by the skid entry.
// Ready to the input side comes straight from a register.
// Reset (aresetn low, synchronous) empties the pipe and the output; data is kept.
module calendar_month_adder_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // start_year[13:0], start_month[17:14], start_day[22:18], month_offset[34:23]
    input  logic [cma_pkg::IN_BYTES*8-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // result_year[13:0], result_month[17:14], result_day[22:18], year_out_of_range[23]
    output logic [cma_pkg::OUT_BYTES*8-1:0]    m_tdata
);
    import cma_pkg::*;

    logic       en;
    logic       in_valid_reg;
    cma_in_t    in_item_reg;
    cma_in_t    in_item_next;
    logic       tot_valid;
    cma_total_t tot_item;
    logic       spl_valid;
    cma_split_t spl_item;
    logic       fix_valid;
    cma_res_t   fix_item;
    cma_res_t   res_item;

    // Whole pipe moves whenever the skid entry is free
    assign s_tready = en;

    // Unpack the stream word
    always_comb begin
        in_item_next.year   = s_tdata[13:0];
        in_item_next.month  = s_tdata[17:14];
        in_item_next.day    = s_tdata[22:18];
        in_item_next.offset = s_tdata[34:23];
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_item_reg <= in_item_next;
        end
    end

    cma_month_total u_total (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_valid_reg),
        .in_item   (in_item_reg),
        .out_valid (tot_valid),
        .out_item  (tot_item)
    );

    cma_year_split u_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (tot_valid),
        .in_item   (tot_item),
        .out_valid (spl_valid),
        .out_item  (spl_item)
    );

    cma_day_fix u_fix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (spl_valid),
        .in_item   (spl_item),
        .out_valid (fix_valid),
        .out_item  (fix_item)
    );

    cma_out_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fix_valid),
        .in_item   (fix_item),
        .in_ready  (en),
        .out_valid (m_tvalid),
        .out_item  (res_item),
        .out_ready (m_tready)
    );

    // Pack the result word
    assign m_tdata = {res_item.oor, res_item.day, res_item.month, res_item.year};

endmodule

/* dv/tb.sv */
// Self-checking bench for calendar_month_adder_unit: directed date table, then random dates.
// Checks each result against a fixed row or the in-bench predictor; depends on rtl/cma_pkg.sv.
`timescale 1ns / 1ps

module tb;
    import cma_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 7;
    localparam int GAP_PCT      = 15;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_REPORTS  = 10;
    localparam int DIRECTED_N   = 25;

    // One directed stimulus row; fixed rows carry a hand-written expectation
    typedef struct packed {
        cma_in_t  date;
        logic     fixed;
        cma_res_t res;
    } date_row_t;

    localparam date_row_t DIRECTED_ROWS [0:DIRECTED_N-1] = '{
        // leap February from a month end, common year, 400 and 100 rules
        '{'{14'd2024, 4'd0,  5'd31, 12'sd1},    1'b1, '{14'd2024, 4'd1,  5'd29, 1'b0}},
        '{'{14'd2023, 4'd0,  5'd31, 12'sd1},    1'b1, '{14'd2023, 4'd1,  5'd28, 1'b0}},
        '{'{14'd2000, 4'd1,  5'd29, 12'sd12},   1'b1, '{14'd2001, 4'd1,  5'd28, 1'b0}},
        '{'{14'd1900, 4'd0,  5'd31, 12'sd1},    1'b1, '{14'd1900, 4'd1,  5'd28, 1'b0}},
        // last day of February sticks to month end, non-last day does not
        '{'{14'd2023, 4'd1,  5'd28, 12'sd1},    1'b1, '{14'd2023, 4'd2,  5'd31, 1'b0}},
        '{'{14'd2024, 4'd1,  5'd28, 12'sd1},    1'b1, '{14'd2024, 4'd2,  5'd28, 1'b0}},
        // negative offset borrows a year
        '{'{14'd2024, 4'd2,  5'd15, -12'sd3},   1'b1, '{14'd2023, 4'd11, 5'd15, 1'b0}},
        // year underflow and overflow saturate, the edge years themselves do not
        '{'{14'd0,    4'd0,  5'd1,  -12'sd1},   1'b1, '{14'd0,    4'd0,  5'd1,  1'b1}},
        '{'{14'd9999, 4'd11, 5'd31, 12'sd1},    1'b1, '{14'd9999, 4'd11, 5'd31, 1'b1}},
        '{'{14'd9999, 4'd11, 5'd1,  12'sd0},    1'b1, '{14'd9999, 4'd11, 5'd1,  1'b0}},
        '{'{14'd0,    4'd1,  5'd29, 12'sd0},    1'b1, '{14'd0,    4'd1,  5'd29, 1'b0}},
        // month above December, day zero, day past month length
        '{'{14'd2020, 4'd15, 5'd10, 12'sd1},    1'b1, '{14'd2021, 4'd0,  5'd10, 1'b0}},
        '{'{14'd2020, 4'd3,  5'd0,  12'sd0},    1'b1, '{14'd2020, 4'd3,  5'd1,  1'b0}},
        '{'{14'd2020, 4'd3,  5'd31, 12'sd1},    1'b1, '{14'd2020, 4'd4,  5'd31, 1'b0}},
        // start year beyond 9999, offset extremes, borrows out of year zero
        '{'{14'd16383, 4'd0, 5'd1,  -12'sd2048}, 1'b1, '{14'd9999, 4'd11, 5'd31, 1'b1}},
        '{'{14'd10000, 4'd0, 5'd15, -12'sd12},  1'b1, '{14'd9999, 4'd0,  5'd15, 1'b0}},
        '{'{14'd16383, 4'd15, 5'd31, 12'sd2047}, 1'b1, '{14'd9999, 4'd11, 5'd31, 1'b1}},
        '{'{14'd10004, 4'd1, 5'd29, -12'sd60},  1'b1, '{14'd9999, 4'd1,  5'd28, 1'b0}},
        '{'{14'd0,    4'd11, 5'd31, -12'sd12},  1'b1, '{14'd0,    4'd0,  5'd1,  1'b1}},
        '{'{14'd0,    4'd11, 5'd31, -12'sd11},  1'b1, '{14'd0,    4'd0,  5'd31, 1'b0}},
        // day clamp into short February, century leap year 2400, 100-year shifts, a predicted row
        '{'{14'd2100, 4'd0,  5'd29, 12'sd1},    1'b1, '{14'd2100, 4'd1,  5'd28, 1'b0}},
        '{'{14'd2400, 4'd0,  5'd30, 12'sd1},    1'b1, '{14'd2400, 4'd1,  5'd29, 1'b0}},
        '{'{14'd2000, 4'd2,  5'd5,  12'sd1200}, 1'b1, '{14'd2100, 4'd2,  5'd5,  1'b0}},
        '{'{14'd2000, 4'd2,  5'd5,  -12'sd1200}, 1'b1, '{14'd1900, 4'd2,  5'd5,  1'b0}},
        '{'{14'd12345, 4'd13, 5'd0, -12'sd1},   1'b0, '{14'd0,    4'd0,  5'd0,  1'b0}}
    };

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_BYTES*8-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_BYTES*8-1:0] m_tdata;

    cma_res_t shifted_date_q [$];
    bit       gaps_on;
    bit       hold_req;
    int       error_count;
    int       sent_count;
    int       checked_count;
    int       saturated_count;
    int       quiet_cycles;

    calendar_month_adder_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic bit gregorian_leap(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int month_length(input int y, input int m);
        case (m)
            1:          return gregorian_leap(y) ? 29 : 28;
            3, 5, 8, 10: return 30;
            default:    return 31;
        endcase
    endfunction

    // Shift a date by a signed month count, keeping month ends and saturating the year
    function automatic cma_res_t predict_shifted_date(input cma_in_t d);
        cma_res_t r;
        int       y;
        int       m;
        int       dd;
        int       off;
        int       total;
        int       len;
        bit       at_end;
        y      = d.year;
        m      = (d.month > MONTH_LAST) ? MONTH_LAST : d.month;
        dd     = (d.day == 5'd0) ? 1 : d.day;
        off    = $signed(d.offset);
        at_end = dd >= month_length(y, m);
        total  = y * 12 + m + off;
        if (total < 0) begin
            r = '{YEAR_MIN, MONTH_JAN, DAY_FIRST, 1'b1};
        end else if (total / 12 > YEAR_MAX) begin
            r = '{YEAR_MAX, MONTH_LAST, DAY_MAX, 1'b1};
        end else begin
            len     = month_length(total / 12, total % 12);
            r.year  = 14'(total / 12);
            r.month = 4'(total % 12);
            r.day   = 5'((at_end || dd > len) ? len : dd);
            r.oor   = 1'b0;
        end
        return r;
    endfunction

    // Random date biased toward calendar corners
    function automatic cma_in_t random_date();
        cma_in_t d;
        int      sel;
        int      m;
        sel = $urandom_range(9);
        case (sel)
            0:       d.year = 14'($urandom_range(16383));
            1:       d.year = 14'($urandom_range(200));
            2:       d.year = 14'($urandom_range(10100, 9800));
            3:       d.year = 14'($urandom_range(99) * 100);
            default: d.year = 14'($urandom_range(2200, 1800));
        endcase
        d.month = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(11));
        m   = (d.month > MONTH_LAST) ? MONTH_LAST : d.month;
        sel = $urandom_range(9);
        if (sel < 2)      d.day = 5'(month_length(d.year, m));
        else if (sel < 3) d.day = 5'($urandom_range(31));
        else if (sel < 6) d.day = 5'($urandom_range(31, 28));
        else              d.day = 5'($urandom_range(28, 1));
        sel = $urandom_range(9);
        if (sel < 4)      d.offset = 12'($urandom_range(60) - 30);
        else if (sel < 6) d.offset = 12'(($urandom_range(200) - 100) * 12);
        else if (sel < 8) d.offset = 12'($urandom_range(2400) - 1200);
        else              d.offset = 12'($urandom_range(4095));
        return d;
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Offer one date, idling first at random while gaps are on; entered and left on a falling edge
    task automatic send_date(input cma_in_t d, input bit fixed, input cma_res_t fixed_res);
        cma_res_t exp_res;
        while (gaps_on && $urandom_range(99) < GAP_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, d.offset, d.day, d.month, d.year};
        do @(posedge aclk); while (!s_tready);
        exp_res        = fixed ? fixed_res : predict_shifted_date(d);
        shifted_date_q = {shifted_date_q, exp_res};
        sent_count++;
        @(negedge aclk);
    endtask

    task automatic send_random_dates(input int n);
        for (int i = 0; i < n; i++) send_date(random_date(), 1'b0, '0);
    endtask

    // Drop valid and hold until every pending result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (shifted_date_q.size() != 0) @(negedge aclk);
    endtask

    // Result side ready: random stalls, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= !aresetn ? 1'b0 :
                            (gaps_on ? ($urandom_range(99) >= GAP_PCT) : 1'b1);
            end
        end
    end

    // Compare each result transfer with the oldest expectation; run the watchdog
    always @(posedge aclk) begin
        cma_res_t want;
        cma_res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[13:0], m_tdata[17:14], m_tdata[22:18], m_tdata[23]};
            if (shifted_date_q.size() == 0) begin
                note_failure($sformatf("result y=%0d m=%0d d=%0d oor=%0d with none expected",
                                       got.year, got.month, got.day, got.oor));
            end else begin
                want = shifted_date_q.pop_front();
                checked_count++;
                if (want.oor) saturated_count++;
                if (got.year != want.year || got.month != want.month ||
                    got.day != want.day || got.oor != want.oor) begin
                    note_failure($sformatf(
                        "expected y=%0d m=%0d d=%0d oor=%0d, got y=%0d m=%0d d=%0d oor=%0d",
                        want.year, want.month, want.day, want.oor,
                        got.year, got.month, got.day, got.oor));
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        gaps_on  = 1'b0;
        hold_req = 1'b0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Walk the directed table back to back
        for (int i = 0; i < DIRECTED_N; i++)
            send_date(DIRECTED_ROWS[i].date, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].res);
        drain_results();

        // Full-rate stretch with no idling on either side
        send_random_dates(400);

        // Long receiver hold-off with random input gaps, then random gaps on both sides
        gaps_on  = 1'b1;
        hold_req = 1'b1;
        send_random_dates(500);
        drain_results();

        send_random_dates(825);
        s_tvalid <= 1'b0;

        // Drain, then let the pipe settle
        while (shifted_date_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (shifted_date_q.size() != 0)
            note_failure($sformatf("%0d results never arrived", shifted_date_q.size()));

        $display("Summary: %0d dates sent (%0d from the directed table), %0d results checked",
                 sent_count, DIRECTED_N, checked_count);
        $display("Summary: %0d saturated years, %0d mismatches", saturated_count, error_count);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
